/* src/bnqs_pkg.sv */
// Shared constants, codes and types of the buzzer note queue sequencer.
`default_nettype none
package bnqs_pkg;

    // Ring of notes; it holds one entry less than its depth.
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    // Field widths.
    localparam int REQ_W   = 2;
    localparam int FREQ_W  = 16;
    localparam int INTEN_W = 9;
    localparam int MS_W    = 16;
    localparam int CMP_W   = 17;
    localparam int PSC_W   = 16;
    localparam int TICKS_W = 32;
    localparam int COUNT_W = 33;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int BASE_W    = 32;
    localparam int PERIOD_W  = 17;
    localparam int RATE_W    = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_TONE_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE  = 2'd2;

    localparam logic [BASE_W-1:0]   RST_TONE_BASE  = 32'd1000000;
    localparam logic [PERIOD_W-1:0] RST_PWM_PERIOD = 17'd1000;
    localparam logic [RATE_W-1:0]   RST_TICK_RATE  = 17'd1000;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_NOTE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP = 2'd2;

    // Bit-serial multiplier: 17 bit multiplicand, 16 bit multiplier.
    localparam int MUL_A_W     = 17;
    localparam int MUL_B_W     = 16;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int MUL_STEPS   = MUL_B_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);

    // Restoring divider, one quotient bit per cycle.
    localparam int DIV_N_W     = 33;
    localparam int DIV_D_W     = 17;
    localparam int DIV_STEPS   = DIV_N_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [DIV_D_W-1:0] MS_PER_S = 17'd1000;

    localparam logic [CMP_W-1:0] CMP_MAX = {CMP_W{1'b1}};
    localparam logic [PSC_W-1:0] PSC_MAX = {PSC_W{1'b1}};

    typedef struct packed {
        logic [PSC_W-1:0]   prescaler;
        logic [CMP_W-1:0]   compare;
        logic [TICKS_W-1:0] on_ticks;
        logic [TICKS_W-1:0] off_ticks;
    } t_note;

    localparam int NOTE_W = $bits(t_note);

endpackage
`default_nettype wire

/* src/bnqs_in_if.sv */
// Request channel: request type and note fields with a valid/ready handshake.
`default_nettype none
interface bnqs_in_if;
    logic                           valid;
    logic                           ready;
    logic [bnqs_pkg::REQ_W-1:0]     req_type;
    logic [bnqs_pkg::FREQ_W-1:0]    freq_hz;
    logic [bnqs_pkg::INTEN_W-1:0]   intensity;
    logic [bnqs_pkg::MS_W-1:0]      on_ms;
    logic [bnqs_pkg::MS_W-1:0]      off_ms;

    modport source (output valid, req_type, freq_hz, intensity, on_ms, off_ms, input ready);
    modport sink   (input valid, req_type, freq_hz, intensity, on_ms, off_ms, output ready);
endinterface
`default_nettype wire

/* src/bnqs_out_if.sv */
// Result channel: held compare and prescaler plus status flags, valid/ready handshake.
`default_nettype none
interface bnqs_out_if;
    logic                         valid;
    logic                         ready;
    logic [bnqs_pkg::CMP_W-1:0]   compare_out;
    logic [bnqs_pkg::PSC_W-1:0]   prescaler_out;
    logic                         accepted;
    logic                         playing;

    modport source (output valid, compare_out, prescaler_out, accepted, playing, input ready);
    modport sink   (input valid, compare_out, prescaler_out, accepted, playing, output ready);
endinterface
`default_nettype wire

/* src/buzzer_note_queue_sequencer_unit.sv */
// Top level of the buzzer note sequencer: request decode, note ring and play timing.
//
//   Channel   Direction  Handshake        Contents
//   i_req     in         valid/ready      req_type, freq_hz, intensity, on_ms, off_ms
//   o_rsp     out        valid/ready      compare_out, prescaler_out, accepted, playing
//   i_cfg_*   in         write enable     register index and 32 bit write data
//
// An enqueue runs the three bit-serial multipliers, then the three restoring dividers and the
// ring write, then loads the output register and returns to idle. A tick runs two update
// steps, the output load and idle; stop, a note on a full ring, a tick on an empty ring and
// other requests go straight to the output load and idle.
// Reset is synchronous and needs no clearing pass. A new transaction is taken once the
// previous result is in the output register; a stalled result blocks only the next one.
`default_nettype none
module buzzer_note_queue_sequencer_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [bnqs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bnqs_pkg::CFG_W-1:0]         i_cfg_wdata,
    bnqs_in_if.sink                                 i_req,
    bnqs_out_if.source                              o_rsp
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_DIV   = 6'b000100,
        S_TICK1 = 6'b001000,
        S_TICK2 = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                                r_state;

    logic [bnqs_pkg::BASE_W-1:0]           r_tone_base;
    logic [bnqs_pkg::PERIOD_W-1:0]         r_pwm_period;
    logic [bnqs_pkg::RATE_W-1:0]           r_tick_rate;

    logic [bnqs_pkg::PTR_W-1:0]            r_write_ptr;
    logic [bnqs_pkg::PTR_W-1:0]            r_read_ptr;
    logic [bnqs_pkg::COUNT_W-1:0]          r_play_count;
    logic [bnqs_pkg::COUNT_W-1:0]          r_total;
    logic [bnqs_pkg::CMP_W-1:0]            r_compare;
    logic [bnqs_pkg::PSC_W-1:0]            r_prescaler;
    logic                                  r_accepted;
    logic [bnqs_pkg::FREQ_W-1:0]           r_freq;
    logic [bnqs_pkg::CMP_W-1:0]            r_note_cmp;

    logic                                  r_out_valid;
    logic [bnqs_pkg::CMP_W-1:0]            r_out_cmp;
    logic [bnqs_pkg::PSC_W-1:0]            r_out_psc;
    logic                                  r_out_acc;
    logic                                  r_out_play;

    logic                                  req_fire;
    logic                                  ring_full;
    logic                                  ring_empty;
    logic                                  note_go;
    logic [bnqs_pkg::PTR_W-1:0]            wr_next;
    logic [bnqs_pkg::PTR_W-1:0]            rd_next;
    logic                                  out_free;

    logic                                  mul_start;
    logic                                  mul_done;
    logic                                  mul_on_done;
    logic                                  mul_off_done;
    logic [bnqs_pkg::MUL_P_W-1:0]          prod_cmp;
    logic [bnqs_pkg::MUL_P_W-1:0]          prod_on;
    logic [bnqs_pkg::MUL_P_W-1:0]          prod_off;

    logic                                  div_start;
    logic                                  div_done;
    logic                                  div_on_done;
    logic                                  div_off_done;
    logic [bnqs_pkg::DIV_N_W-1:0]          quot_psc;
    logic [bnqs_pkg::DIV_N_W-1:0]          quot_on;
    logic [bnqs_pkg::DIV_N_W-1:0]          quot_off;

    logic                                  ram_we;
    bnqs_pkg::t_note                       ram_wdata;
    bnqs_pkg::t_note                       head_note;
    logic [bnqs_pkg::NOTE_W-1:0]           ram_rdata;

    logic [bnqs_pkg::CMP_W-1:0]            cmp_sat;
    logic [bnqs_pkg::PSC_W-1:0]            psc_sat;

    function automatic logic [bnqs_pkg::PTR_W-1:0] ring_next(
        input logic [bnqs_pkg::PTR_W-1:0] p
    );
        return (p == bnqs_pkg::PTR_W'(bnqs_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign req_fire   = i_req.valid && i_req.ready;
    assign wr_next    = ring_next(r_write_ptr);
    assign rd_next    = ring_next(r_read_ptr);
    assign ring_full  = (wr_next == r_read_ptr);
    assign ring_empty = (r_read_ptr == r_write_ptr);
    assign note_go    = req_fire && (i_req.req_type == bnqs_pkg::REQ_NOTE) && !ring_full;
    assign out_free   = !r_out_valid || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_base  <= bnqs_pkg::RST_TONE_BASE;
            r_pwm_period <= bnqs_pkg::RST_PWM_PERIOD;
            r_tick_rate  <= bnqs_pkg::RST_TICK_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bnqs_pkg::CFG_TONE_BASE: begin
                    r_tone_base <= i_cfg_wdata[bnqs_pkg::BASE_W-1:0];
                end
                bnqs_pkg::CFG_PWM_PERIOD: begin
                    r_pwm_period <= i_cfg_wdata[bnqs_pkg::PERIOD_W-1:0];
                end
                bnqs_pkg::CFG_TICK_RATE: begin
                    r_tick_rate <= i_cfg_wdata[bnqs_pkg::RATE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Note conversion: products first, then the quotients.
    assign mul_start = note_go;

    bnqs_serial_mul u_mul_cmp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (r_pwm_period),
        .i_mplier (bnqs_pkg::MUL_B_W'(i_req.intensity)),
        .o_done   (mul_done),
        .o_prod   (prod_cmp)
    );

    bnqs_serial_mul u_mul_on (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (r_tick_rate),
        .i_mplier (i_req.on_ms),
        .o_done   (mul_on_done),
        .o_prod   (prod_on)
    );

    bnqs_serial_mul u_mul_off (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (r_tick_rate),
        .i_mplier (i_req.off_ms),
        .o_done   (mul_off_done),
        .o_prod   (prod_off)
    );

    assign div_start = (r_state == S_MUL) && mul_done;

    bnqs_serial_div u_div_psc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (bnqs_pkg::DIV_N_W'(r_tone_base)),
        .i_divisor  (bnqs_pkg::DIV_D_W'(r_freq)),
        .o_done     (div_done),
        .o_quot     (quot_psc)
    );

    bnqs_serial_div u_div_on (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod_on),
        .i_divisor  (bnqs_pkg::MS_PER_S),
        .o_done     (div_on_done),
        .o_quot     (quot_on)
    );

    bnqs_serial_div u_div_off (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod_off),
        .i_divisor  (bnqs_pkg::MS_PER_S),
        .o_done     (div_off_done),
        .o_quot     (quot_off)
    );

    // The compare value is the product shifted down by eight, saturated to 17 bits.
    assign cmp_sat = (|prod_cmp[bnqs_pkg::MUL_P_W-1:bnqs_pkg::CMP_W+8])
                     ? bnqs_pkg::CMP_MAX : prod_cmp[bnqs_pkg::CMP_W+7:8];
    assign psc_sat = (|quot_psc[bnqs_pkg::DIV_N_W-1:bnqs_pkg::PSC_W])
                     ? bnqs_pkg::PSC_MAX : quot_psc[bnqs_pkg::PSC_W-1:0];

    assign ram_we = (r_state == S_DIV) && div_done;

    always_comb begin
        ram_wdata.prescaler = psc_sat;
        ram_wdata.compare   = r_note_cmp;
        ram_wdata.on_ticks  = quot_on[bnqs_pkg::TICKS_W-1:0];
        ram_wdata.off_ticks = quot_off[bnqs_pkg::TICKS_W-1:0];
    end

    bnqs_ram #(
        .WIDTH (bnqs_pkg::NOTE_W),
        .DEPTH (bnqs_pkg::QUEUE_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_write_ptr),
        .i_wdata (ram_wdata),
        .i_raddr (r_read_ptr),
        .o_rdata (ram_rdata)
    );

    assign head_note = bnqs_pkg::t_note'(ram_rdata);

    // Sequencer and ring state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_write_ptr  <= '0;
            r_read_ptr   <= '0;
            r_play_count <= '0;
            r_compare    <= '0;
            r_prescaler  <= '0;
            r_accepted   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        r_accepted <= 1'b0;
                        r_state    <= S_OUT;
                        case (i_req.req_type)
                            bnqs_pkg::REQ_NOTE: begin
                                if (!ring_full) begin
                                    r_state <= S_MUL;
                                end
                            end
                            bnqs_pkg::REQ_TICK: begin
                                if (!ring_empty) begin
                                    r_state <= S_TICK1;
                                end
                            end
                            bnqs_pkg::REQ_STOP: begin
                                r_write_ptr  <= '0;
                                r_read_ptr   <= '0;
                                r_play_count <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    if (mul_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_write_ptr <= wr_next;
                        r_accepted  <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_TICK1: begin
                    if (r_play_count <= bnqs_pkg::COUNT_W'(head_note.on_ticks)) begin
                        r_compare   <= head_note.compare;
                        r_prescaler <= head_note.prescaler;
                    end else begin
                        r_compare <= '0;
                    end
                    r_play_count <= r_play_count + 1'b1;
                    r_state      <= S_TICK2;
                end
                S_TICK2: begin
                    // The counter has already been advanced for this tick.
                    if (r_play_count >= r_total) begin
                        r_read_ptr   <= rd_next;
                        r_play_count <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_freq <= i_req.freq_hz;
        end
        if (div_start) begin
            r_note_cmp <= cmp_sat;
        end
        if (r_state == S_TICK1) begin
            r_total <= bnqs_pkg::COUNT_W'(head_note.on_ticks)
                     + bnqs_pkg::COUNT_W'(head_note.off_ticks);
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out_cmp  <= r_compare;
            r_out_psc  <= r_prescaler;
            r_out_acc  <= r_accepted;
            r_out_play <= !ring_empty;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.compare_out   = r_out_cmp;
    assign o_rsp.prescaler_out = r_out_psc;
    assign o_rsp.accepted      = r_out_acc;
    assign o_rsp.playing       = r_out_play;

    // A stored note always leaves the ring non-empty.
    a_acc_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.accepted) |-> o_rsp.playing)
        else $error("accepted note reported with an empty ring");

    // All three multipliers run in lockstep, and so do the dividers.
    a_units_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_done == mul_on_done) && (mul_done == mul_off_done)
        && (div_done == div_on_done) && (div_done == div_off_done))
        else $error("serial arithmetic units out of step");

    // The multipliers finish only while the sequencer waits on them.
    a_mul_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL) ##1 (r_state == S_DIV))
        else $error("multiplier result arrived outside the conversion");

    // A tick only advances the head of a non-empty ring.
    a_tick_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK2) |-> !ring_empty)
        else $error("tick processed on an empty ring");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_write_ptr <= bnqs_pkg::PTR_W'(bnqs_pkg::QUEUE_DEPTH - 1))
        && (r_read_ptr <= bnqs_pkg::PTR_W'(bnqs_pkg::QUEUE_DEPTH - 1)))
        else $error("ring pointer beyond the queue depth");

endmodule
`default_nettype wire

/* src/bnqs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bnqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* src/bnqs_serial_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none
module bnqs_serial_mul (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [bnqs_pkg::MUL_A_W-1:0]   i_mcand,
    input  wire logic [bnqs_pkg::MUL_B_W-1:0]   i_mplier,
    output logic                                o_done,
    output logic      [bnqs_pkg::MUL_P_W-1:0]   o_prod
);

    logic                              r_busy;
    logic                              r_done;
    logic [bnqs_pkg::MUL_CNT_W-1:0]    r_cnt;
    logic [bnqs_pkg::MUL_P_W-1:0]      r_acc;
    logic [bnqs_pkg::MUL_P_W-1:0]      r_mcand;
    logic [bnqs_pkg::MUL_B_W-1:0]      r_mplier;
    logic [bnqs_pkg::MUL_P_W-1:0]      n_acc;

    assign n_acc = r_mplier[0] ? r_acc + r_mcand : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= bnqs_pkg::MUL_CNT_W'(bnqs_pkg::MUL_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= bnqs_pkg::MUL_P_W'(i_mcand);
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            r_acc    <= n_acc;
            r_mcand  <= {r_mcand[bnqs_pkg::MUL_P_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[bnqs_pkg::MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

/* src/bnqs_serial_div.sv */
// Restoring divider that produces one quotient bit per cycle, MSB first.
`default_nettype none
module bnqs_serial_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [bnqs_pkg::DIV_N_W-1:0]   i_dividend,
    input  wire logic [bnqs_pkg::DIV_D_W-1:0]   i_divisor,
    output logic                                o_done,
    output logic      [bnqs_pkg::DIV_N_W-1:0]   o_quot
);

    logic                              r_busy;
    logic                              r_done;
    logic [bnqs_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [bnqs_pkg::DIV_N_W-1:0]      r_quo;
    logic [bnqs_pkg::DIV_D_W:0]        r_rem;
    logic [bnqs_pkg::DIV_D_W-1:0]      r_dvs;
    logic [bnqs_pkg::DIV_D_W:0]        n_trial;
    logic                              n_fits;
    logic [bnqs_pkg::DIV_D_W:0]        n_rem;

    // The quotient register holds the unused dividend bits at its top and
    // collects quotient bits at its bottom. A zero divisor gives all ones.
    always_comb begin
        n_trial = {r_rem[bnqs_pkg::DIV_D_W-1:0], r_quo[bnqs_pkg::DIV_N_W-1]};
        n_fits  = (n_trial >= {1'b0, r_dvs});
        n_rem   = n_fits ? n_trial - {1'b0, r_dvs} : n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= bnqs_pkg::DIV_CNT_W'(bnqs_pkg::DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[bnqs_pkg::DIV_N_W-2:0], n_fits};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
`default_nettype wire
